// ----- rtl/core/tcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tcl_pkg: shared types and codes of the two-class concurrency limiter
// Operation and status codes, config register indexes, controller commands.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int USE_W = 16;
  localparam int CNT_W = 32;
  localparam int CAP_W = 7;

  typedef enum logic [1:0] {
    OP_REG_PRODUCT  = 2'd0,
    OP_REG_LISTENER = 2'd1,
    OP_ACQUIRE      = 2'd2,
    OP_RELEASE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_PRODUCT_OVER = 3'd2,
    ST_LISTENER_OVER = 3'd3,
    ST_KEY_MISSING  = 3'd4
  } status_t;

  localparam logic [1:0] CFG_PRODUCT_CAP  = 2'd0;
  localparam logic [1:0] CFG_LISTENER_CAP = 2'd1;
  localparam logic [1:0] CFG_WARN_LEVEL   = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input transaction, clear search state
    logic search;      // step both table scans one entry
    logic apply;       // compute and write back counters
    logic emit;        // present the result
  } tcl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_done;
  } tcl_stat_t;

endpackage

// ----- rtl/core/tcl_ram.sv -----
// ----------------------------------------------------------------------------
// tcl_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tcl_table.sv -----
// ----------------------------------------------------------------------------
// tcl_table: one keyed class table
// Holds keys, limits and counters, scans for the earliest match one entry per
// cycle and performs the counter read-modify-write for the matched entry.
// ----------------------------------------------------------------------------
module tcl_table
  import tcl_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      capture,
  input  logic                      search,
  input  logic [KEY_BITS-1:0]       key,
  input  logic                      key_given,
  input  logic [CAP_W-1:0]          capacity,
  // Register an entry.
  input  logic                      reg_we,
  input  logic [USE_W-1:0]          reg_limit,
  output logic                      full,
  // Counter write-back for the matched entry.
  input  logic                      cnt_we,
  input  logic [USE_W-1:0]          use_wdata,
  input  logic [CNT_W-1:0]          succ_wdata,
  input  logic [CNT_W-1:0]          fail_wdata,
  output logic                      done,
  output logic                      found,
  output logic [USE_W-1:0]          limit_q,
  output logic [USE_W-1:0]          use_q,
  output logic [CNT_W-1:0]          succ_q,
  output logic [CNT_W-1:0]          fail_q
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(ENTRIES + 1);

  logic [NW-1:0]       used_r, used_nxt;
  logic [NW:0]         scan_r, scan_nxt;     // next entry to issue a read for
  logic                rd_vld_r;             // RAM output holds entry scan_r-1
  logic                found_r, found_nxt;
  logic                done_r, done_nxt;
  logic [AW-1:0]       hit_r, hit_nxt;
  logic [AW-1:0]       raddr, waddr;
  logic [KEY_BITS-1:0] key_rd;
  logic [USE_W-1:0]    lim_rd, use_rd;
  logic [CNT_W-1:0]    succ_rd, fail_rd;
  logic [NW-1:0]       cap_eff;
  logic                match;
  logic                we_any;

  assign cap_eff = (int'(capacity) > ENTRIES) ? NW'(ENTRIES) : NW'(capacity);
  assign full = (used_r >= cap_eff);

  // While this table still scans, the read address walks the table; once it
  // is done it rests on the hit so the counters of that entry appear on the
  // outputs, even while the other table keeps scanning.
  assign raddr = (search && !done_r) ? AW'(scan_r) : hit_r;
  assign waddr = reg_we ? AW'(used_r) : hit_r;
  assign we_any = reg_we || cnt_we;

  tcl_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(reg_we), .waddr(waddr), .wdata(key), .raddr(raddr),
    .rdata(key_rd));
  tcl_ram #(.WIDTH(USE_W), .DEPTH(ENTRIES)) u_lim (
    .clk(clk), .we(reg_we), .waddr(waddr), .wdata(reg_limit), .raddr(raddr),
    .rdata(lim_rd));
  tcl_ram #(.WIDTH(USE_W), .DEPTH(ENTRIES)) u_use (
    .clk(clk), .we(we_any), .waddr(waddr),
    .wdata(reg_we ? '0 : use_wdata), .raddr(raddr), .rdata(use_rd));
  tcl_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_succ (
    .clk(clk), .we(we_any), .waddr(waddr),
    .wdata(reg_we ? '0 : succ_wdata), .raddr(raddr), .rdata(succ_rd));
  tcl_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_fail (
    .clk(clk), .we(we_any), .waddr(waddr),
    .wdata(reg_we ? '0 : fail_wdata), .raddr(raddr), .rdata(fail_rd));

  assign match = rd_vld_r && !found_r && (key_rd == key);

  always_comb begin
    scan_nxt  = scan_r;
    found_nxt = found_r;
    done_nxt  = done_r;
    hit_nxt   = hit_r;
    used_nxt  = used_r;
    if (reg_we) begin
      used_nxt = used_r + NW'(1);
    end
    if (capture) begin
      scan_nxt  = '0;
      found_nxt = 1'b0;
      done_nxt  = !key_given || (used_r == '0);
    end else if (search && !done_r) begin
      scan_nxt = scan_r + (NW+1)'(1);
      if (match) begin
        found_nxt = 1'b1;
        done_nxt  = 1'b1;
        hit_nxt   = AW'(scan_r - (NW+1)'(1));
      end else if (scan_r == {1'b0, used_r}) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      done_r   <= 1'b1;
      hit_r    <= '0;
    end else begin
      used_r   <= used_nxt;
      scan_r   <= scan_nxt;
      rd_vld_r <= search && !done_r && !match && (scan_r < {1'b0, used_r});
      found_r  <= found_nxt;
      done_r   <= done_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign done    = done_r;
  assign found   = found_r;
  assign limit_q = lim_rd;
  assign use_q   = use_rd;
  assign succ_q  = succ_rd;
  assign fail_q  = fail_rd;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NW'(ENTRIES))
    else $error("entry count beyond table depth");
  a_no_reg_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    reg_we |-> !full)
    else $error("register into a full table");
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> done_r)
    else $error("match without finished scan");

endmodule

// ----- rtl/core/tcl_datapath.sv -----
// ----------------------------------------------------------------------------
// tcl_datapath: operand capture, both tables and the result computation
// Runs the table scans on command and computes limit checks, warnings and
// counter updates in the apply step.
// ----------------------------------------------------------------------------
module tcl_datapath
  import tcl_pkg::*;
#(
  parameter int PRODUCT_ENTRIES  = 64,
  parameter int LISTENER_ENTRIES = 64,
  parameter int KEY_BITS         = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcl_cmd_t          cmd,
  output tcl_stat_t         stat,
  input  logic [1:0]        in_operation,
  input  logic [63:0]       in_product_key,
  input  logic              in_product_given,
  input  logic [63:0]       in_listener_key,
  input  logic              in_listener_given,
  input  logic [15:0]       in_entry_limit,
  input  logic              in_outcome_success,
  input  logic [CAP_W-1:0]  product_cap,
  input  logic [CAP_W-1:0]  listener_cap,
  input  logic [USE_W-1:0]  warn_level,
  output logic              out_strobe,
  output logic [2:0]        out_status,
  output logic              out_product_found,
  output logic              out_listener_found,
  output logic              out_product_warning,
  output logic              out_listener_warning,
  output logic [15:0]       out_product_in_use,
  output logic [15:0]       out_listener_in_use
);

  localparam logic [USE_W-1:0] USE_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  op_t                 op_r;
  logic [KEY_BITS-1:0] pkey_r, lkey_r;
  logic                pgiven_r, lgiven_r, ok_r;
  logic [USE_W-1:0]    limit_r;

  logic p_full, l_full, p_done, l_done, p_found, l_found;
  logic [USE_W-1:0] p_lim, p_use, l_lim, l_use;
  logic [CNT_W-1:0] p_succ, p_fail, l_succ, l_fail;
  logic p_reg_we, l_reg_we, p_cnt_we, l_cnt_we;
  logic [USE_W-1:0] p_use_w, l_use_w;
  logic [CNT_W-1:0] p_succ_w, p_fail_w, l_succ_w, l_fail_w;

  status_t          status_c;
  logic             pf_c, lf_c, pw_c, lw_c;
  logic [USE_W-1:0] pu_c, lu_c;

  logic             strobe_r;
  status_t          status_r;
  logic             pf_r, lf_r, pw_r, lw_r;
  logic [USE_W-1:0] pu_r, lu_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(in_operation);
      pkey_r   <= in_product_key[KEY_BITS-1:0];
      lkey_r   <= in_listener_key[KEY_BITS-1:0];
      pgiven_r <= in_product_given;
      lgiven_r <= in_listener_given;
      ok_r     <= in_outcome_success;
      limit_r  <= in_entry_limit;
    end
  end

  logic p_search_en;
  assign p_search_en = (op_r == OP_ACQUIRE) || (op_r == OP_RELEASE);

  tcl_table #(.ENTRIES(PRODUCT_ENTRIES), .KEY_BITS(KEY_BITS)) u_ptab (
    .clk(clk), .rst_n(rst_n), .capture(cmd.capture), .search(cmd.search),
    .key(cmd.capture ? in_product_key[KEY_BITS-1:0] : pkey_r),
    .key_given(in_product_given && in_operation[1]),
    .capacity(product_cap), .reg_we(p_reg_we), .reg_limit(limit_r),
    .full(p_full), .cnt_we(p_cnt_we), .use_wdata(p_use_w),
    .succ_wdata(p_succ_w), .fail_wdata(p_fail_w), .done(p_done),
    .found(p_found), .limit_q(p_lim), .use_q(p_use), .succ_q(p_succ),
    .fail_q(p_fail));

  tcl_table #(.ENTRIES(LISTENER_ENTRIES), .KEY_BITS(KEY_BITS)) u_ltab (
    .clk(clk), .rst_n(rst_n), .capture(cmd.capture), .search(cmd.search),
    .key(cmd.capture ? in_listener_key[KEY_BITS-1:0] : lkey_r),
    .key_given(in_listener_given && in_operation[1]),
    .capacity(listener_cap), .reg_we(l_reg_we), .reg_limit(limit_r),
    .full(l_full), .cnt_we(l_cnt_we), .use_wdata(l_use_w),
    .succ_wdata(l_succ_w), .fail_wdata(l_fail_w), .done(l_done),
    .found(l_found), .limit_q(l_lim), .use_q(l_use), .succ_q(l_succ),
    .fail_q(l_fail));

  assign stat.search_done = (p_done && l_done) || !p_search_en;

  // Result and write-back values, evaluated in the apply step once the RAM
  // outputs carry the matched entries.
  always_comb begin
    logic [USE_W-1:0] pwarn, lwarn;
    logic             p_rej, l_rej;
    status_c = ST_OK;
    pf_c = 1'b0; lf_c = 1'b0; pw_c = 1'b0; lw_c = 1'b0;
    pu_c = '0;   lu_c = '0;
    p_reg_we = 1'b0; l_reg_we = 1'b0; p_cnt_we = 1'b0; l_cnt_we = 1'b0;
    p_use_w = p_use; l_use_w = l_use;
    p_succ_w = p_succ; p_fail_w = p_fail; l_succ_w = l_succ; l_fail_w = l_fail;
    pwarn = (p_lim != '0) ? (p_lim >> 1) : warn_level;
    lwarn = (l_lim != '0) ? (l_lim >> 1) : warn_level;
    p_rej = p_found && (p_lim != '0) && (p_use >= p_lim);
    l_rej = l_found && (l_lim != '0) && (l_use >= l_lim);
    unique case (op_r)
      OP_REG_PRODUCT, OP_REG_LISTENER: begin
        if (!((op_r == OP_REG_PRODUCT) ? pgiven_r : lgiven_r)) begin
          status_c = ST_KEY_MISSING;
        end else if ((op_r == OP_REG_PRODUCT) ? p_full : l_full) begin
          status_c = ST_FULL;
        end else begin
          p_reg_we = cmd.apply && (op_r == OP_REG_PRODUCT);
          l_reg_we = cmd.apply && (op_r == OP_REG_LISTENER);
        end
      end
      OP_ACQUIRE: begin
        pf_c = p_found;
        if (p_rej) begin
          status_c = ST_PRODUCT_OVER;
          pu_c = p_use;
        end else begin
          if (p_found) begin
            p_use_w = (p_use < USE_MAX) ? p_use + USE_W'(1) : p_use;
            pu_c = p_use_w;
            pw_c = (p_use_w >= pwarn);
          end
          lf_c = l_found;
          if (l_rej) begin
            // Listener refuses: the product entry keeps its old count.
            status_c = ST_LISTENER_OVER;
            lu_c = l_use;
            p_use_w = p_use;
            pu_c = p_found ? p_use : '0;
            pw_c = 1'b0;
          end else if (l_found) begin
            l_use_w = (l_use < USE_MAX) ? l_use + USE_W'(1) : l_use;
            lu_c = l_use_w;
            lw_c = (l_use_w >= lwarn);
            l_cnt_we = cmd.apply;
          end
          p_cnt_we = cmd.apply && p_found;
        end
      end
      OP_RELEASE: begin
        pf_c = p_found;
        lf_c = l_found;
        if (p_found) begin
          p_use_w = (p_use != '0) ? p_use - USE_W'(1) : p_use;
          pu_c = p_use_w;
          if (ok_r) begin
            p_succ_w = (p_succ < CNT_MAX) ? p_succ + CNT_W'(1) : p_succ;
          end else begin
            p_fail_w = (p_fail < CNT_MAX) ? p_fail + CNT_W'(1) : p_fail;
          end
          p_cnt_we = cmd.apply;
        end
        if (l_found) begin
          l_use_w = (l_use != '0) ? l_use - USE_W'(1) : l_use;
          lu_c = l_use_w;
          if (ok_r) begin
            l_succ_w = (l_succ < CNT_MAX) ? l_succ + CNT_W'(1) : l_succ;
          end else begin
            l_fail_w = (l_fail < CNT_MAX) ? l_fail + CNT_W'(1) : l_fail;
          end
          l_cnt_we = cmd.apply;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.apply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r <= status_c;
      pf_r <= pf_c; lf_r <= lf_c; pw_r <= pw_c; lw_r <= lw_c;
      pu_r <= pu_c; lu_r <= lu_c;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_status           = status_r;
  assign out_product_found    = pf_r;
  assign out_listener_found   = lf_r;
  assign out_product_warning  = pw_r;
  assign out_listener_warning = lw_r;
  assign out_product_in_use   = pu_r;
  assign out_listener_in_use  = lu_r;

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.apply))
    else $error("result without apply step");
  a_one_reg_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_reg_we && l_reg_we))
    else $error("both tables registered at once");
  a_reg_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_FULL) |-> !out_product_found && !out_listener_found)
    else $error("found flag on a table-full result");

endmodule

// ----- rtl/core/tcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcl_ctrl: transaction sequencer
// Steps capture, table scan, counter update and result for each transaction.
// ----------------------------------------------------------------------------
module tcl_ctrl
  import tcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output tcl_cmd_t  cmd,
  input  tcl_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_APPLY, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_SEARCH;
      S_SEARCH: if (stat.search_done) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_EMIT;
      S_EMIT:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy        = busy_r;
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.search  = (state_r == S_SEARCH);
  assign cmd.apply   = (state_r == S_APPLY);
  assign cmd.emit    = (state_r == S_EMIT);

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE))
    else $error("busy out of step with state");
  a_apply_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> cmd.emit)
    else $error("apply not followed by result");
  a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.search)
    else $error("capture not followed by search");

endmodule

// ----- rtl/core/two_class_concurrency_limiter.sv -----
// ----------------------------------------------------------------------------
// two_class_concurrency_limiter: per-class admission limiter
// Product and listener tables with limits, in-use and outcome counters.
// ----------------------------------------------------------------------------
// Usage: raise start with the input fields while busy is low; the transaction
// is taken at that edge and busy rises. Register operations append a key and
// limit; acquire and release look up both keys and update counters.
// The result appears on the out_ ports, marked by out_strobe for one cycle.
// The receiver cannot stall the block.
// Sequence: scans read one table entry per cycle from the key RAMs, both tables
// side by side. A register passes from start through the search, apply and emit
// states to the strobe; acquire or release stays in the search state until the
// longer scan reaches the match (or passes the last entry). Start is accepted
// again the cycle after the strobe.
// Configuration writes (cfg_valid/cfg_ready, index 0 product capacity,
// 1 listener capacity, 2 default warn level) are always ready and must occur
// while the block is idle. Reset empties both tables, sets capacities to 64
// and the warn level to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_class_concurrency_limiter
  import tcl_pkg::*;
#(
  parameter int PRODUCT_ENTRIES  = 64,
  parameter int LISTENER_ENTRIES = 64,
  parameter int KEY_BITS         = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_product_key,
  input  logic        in_product_given,
  input  logic [63:0] in_listener_key,
  input  logic        in_listener_given,
  input  logic [15:0] in_entry_limit,
  input  logic        in_outcome_success,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_product_found,
  output logic        out_listener_found,
  output logic        out_product_warning,
  output logic        out_listener_warning,
  output logic [15:0] out_product_in_use,
  output logic [15:0] out_listener_in_use,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [CAP_W-1:0] pcap_r, lcap_r;
  logic [USE_W-1:0] warn_r;
  tcl_cmd_t         cmd;
  tcl_stat_t        stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcap_r <= CAP_W'(64);
      lcap_r <= CAP_W'(64);
      warn_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRODUCT_CAP:  pcap_r <= cfg_data[CAP_W-1:0];
        CFG_LISTENER_CAP: lcap_r <= cfg_data[CAP_W-1:0];
        CFG_WARN_LEVEL:   warn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
    .stat(stat));

  tcl_datapath #(
    .PRODUCT_ENTRIES(PRODUCT_ENTRIES), .LISTENER_ENTRIES(LISTENER_ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_operation(in_operation), .in_product_key(in_product_key),
    .in_product_given(in_product_given), .in_listener_key(in_listener_key),
    .in_listener_given(in_listener_given), .in_entry_limit(in_entry_limit),
    .in_outcome_success(in_outcome_success), .product_cap(pcap_r),
    .listener_cap(lcap_r), .warn_level(warn_r), .out_strobe(out_strobe),
    .out_status(out_status), .out_product_found(out_product_found),
    .out_listener_found(out_listener_found),
    .out_product_warning(out_product_warning),
    .out_listener_warning(out_listener_warning),
    .out_product_in_use(out_product_in_use),
    .out_listener_in_use(out_listener_in_use));

  a_no_start_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result while idle");
  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("busy after result");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted start without busy");

endmodule

// ----- test/two_class_concurrency_limiter_tb.sv -----
// ----------------------------------------------------------------------------
// two_class_concurrency_limiter_tb: self-checking bench for the limiter
// Drives register, acquire and release transactions, with random gaps or back to back, keeps
// its own copy of both tables and compares every strobed result in order.
// ----------------------------------------------------------------------------
module two_class_concurrency_limiter_tb;
  import tcl_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    op_t         op;
    logic [63:0] pkey;
    logic        pgiven;
    logic [63:0] lkey;
    logic        lgiven;
    logic [15:0] limit;
    logic        ok;
  } request_t;

  typedef struct {
    status_t     status;
    logic        pf;
    logic        lf;
    logic        pw;
    logic        lw;
    logic [15:0] pu;
    logic [15:0] lu;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [63:0] in_product_key;
  logic        in_product_given;
  logic [63:0] in_listener_key;
  logic        in_listener_given;
  logic [15:0] in_entry_limit;
  logic        in_outcome_success;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic        out_product_found;
  logic        out_listener_found;
  logic        out_product_warning;
  logic        out_listener_warning;
  logic [15:0] out_product_in_use;
  logic [15:0] out_listener_in_use;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  two_class_concurrency_limiter DUT (.*);

  // Table 0 holds products, table 1 listeners.
  logic [63:0] tbl_key [2][DEPTH];
  logic [15:0] tbl_limit [2][DEPTH];
  logic [15:0] tbl_use [2][DEPTH];
  int          tbl_used [2];
  int          tbl_cap [2];
  logic [15:0] warn_default;

  request_t    pending_requests[$];
  verdict_t    expected_verdicts[$];
  logic [63:0] key_pool [2][$];
  bit          took;
  bit          cfg_taken;
  bit          steady;
  int          errors;
  int          checked;
  int          status_seen [5];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
  endtask

  function automatic int lookup(input int t, input logic [63:0] key);
    for (int i = 0; i < tbl_used[t]; i++)
      if (tbl_key[t][i] == key) return i;
    return -1;
  endfunction

  function automatic status_t append_entry(input int t, input logic [63:0] key,
                                           input logic given, input logic [15:0] lim);
    int cap;
    cap = tbl_cap[t] > DEPTH ? DEPTH : tbl_cap[t];
    if (!given) return ST_KEY_MISSING;
    if (tbl_used[t] >= cap) return ST_FULL;
    tbl_key[t][tbl_used[t]] = key;
    tbl_limit[t][tbl_used[t]] = lim;
    tbl_use[t][tbl_used[t]] = '0;
    tbl_used[t]++;
    return ST_OK;
  endfunction

  function automatic verdict_t admit(input request_t r);
    verdict_t v;
    int pi;
    int li;
    bit pinc;
    logic [15:0] lvl;
    v = '{ST_OK, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0};
    pi = -1;
    li = -1;
    pinc = 1'b0;
    case (r.op)
      OP_REG_PRODUCT:  v.status = append_entry(0, r.pkey, r.pgiven, r.limit);
      OP_REG_LISTENER: v.status = append_entry(1, r.lkey, r.lgiven, r.limit);
      OP_ACQUIRE: begin
        if (r.pgiven) pi = lookup(0, r.pkey);
        if (pi >= 0) begin
          v.pf = 1'b1;
          if (tbl_limit[0][pi] != 0 && tbl_use[0][pi] >= tbl_limit[0][pi]) begin
            v.status = ST_PRODUCT_OVER;
          end else begin
            if (tbl_use[0][pi] != 16'hFFFF) begin
              tbl_use[0][pi]++;
              pinc = 1'b1;
            end
            lvl = tbl_limit[0][pi] != 0 ? tbl_limit[0][pi] >> 1 : warn_default;
            v.pw = tbl_use[0][pi] >= lvl;
          end
          v.pu = tbl_use[0][pi];
        end
        if (v.status == ST_OK && r.lgiven) li = lookup(1, r.lkey);
        if (li >= 0) begin
          v.lf = 1'b1;
          if (tbl_limit[1][li] != 0 && tbl_use[1][li] >= tbl_limit[1][li]) begin
            // The listener refused, so the product slot taken above is given back.
            v.status = ST_LISTENER_OVER;
            if (pinc) begin
              tbl_use[0][pi]--;
              v.pu = tbl_use[0][pi];
            end
            v.pw = 1'b0;
          end else begin
            if (tbl_use[1][li] != 16'hFFFF) tbl_use[1][li]++;
            lvl = tbl_limit[1][li] != 0 ? tbl_limit[1][li] >> 1 : warn_default;
            v.lw = tbl_use[1][li] >= lvl;
          end
          v.lu = tbl_use[1][li];
        end
      end
      default: begin
        if (r.pgiven) pi = lookup(0, r.pkey);
        if (pi >= 0) begin
          v.pf = 1'b1;
          if (tbl_use[0][pi] != 0) tbl_use[0][pi]--;
          v.pu = tbl_use[0][pi];
        end
        if (r.lgiven) li = lookup(1, r.lkey);
        if (li >= 0) begin
          v.lf = 1'b1;
          if (tbl_use[1][li] != 0) tbl_use[1][li]--;
          v.lu = tbl_use[1][li];
        end
      end
    endcase
    return v;
  endfunction

  // Driver: offers the head of the queue, with random gaps unless steady is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        void'(pending_requests.pop_front());
        took = 0;
      end
      if (pending_requests.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
        start              <= 1'b1;
        in_operation       <= pending_requests[0].op;
        in_product_key     <= pending_requests[0].pkey;
        in_product_given   <= pending_requests[0].pgiven;
        in_listener_key    <= pending_requests[0].lkey;
        in_listener_given  <= pending_requests[0].lgiven;
        in_entry_limit     <= pending_requests[0].limit;
        in_outcome_success <= pending_requests[0].ok;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted transaction and checks each result.
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRODUCT_CAP:  tbl_cap[0] = int'(cfg_data[6:0]);
          CFG_LISTENER_CAP: tbl_cap[1] = int'(cfg_data[6:0]);
          CFG_WARN_LEVEL:   warn_default = cfg_data;
          default: ;
        endcase
        cfg_taken = 1;
      end
      if (out_strobe) begin
        if (expected_verdicts.size() == 0) begin
          report("unexpected result", 64'(out_status), 64'd0);
        end else begin
          w = expected_verdicts.pop_front();
          if (out_status !== w.status)
            report("status", 64'(out_status), 64'(w.status));
          if (out_product_found !== w.pf)
            report("product_found", 64'(out_product_found), 64'(w.pf));
          if (out_listener_found !== w.lf)
            report("listener_found", 64'(out_listener_found), 64'(w.lf));
          if (out_product_warning !== w.pw)
            report("product_warning", 64'(out_product_warning), 64'(w.pw));
          if (out_listener_warning !== w.lw)
            report("listener_warning", 64'(out_listener_warning), 64'(w.lw));
          if (out_product_in_use !== w.pu)
            report("product_in_use", 64'(out_product_in_use), 64'(w.pu));
          if (out_listener_in_use !== w.lu)
            report("listener_in_use", 64'(out_listener_in_use), 64'(w.lu));
          status_seen[w.status]++;
        end
        checked++;
      end
      if (start && !busy) begin
        expected_verdicts.push_back(admit(pending_requests[0]));
        took = 1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_taken = 0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_requests.size() != 0 || expected_verdicts.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic push(input op_t op, input logic [63:0] pk, input logic pg,
                      input logic [63:0] lk, input logic lg,
                      input logic [15:0] lim, input logic ok);
    request_t r;
    r = '{op, pk, pg, lk, lg, lim, ok};
    if (op == OP_REG_PRODUCT && pg) key_pool[0].push_back(pk);
    if (op == OP_REG_LISTENER && lg) key_pool[1].push_back(lk);
    pending_requests.push_back(r);
  endtask

  function automatic logic [63:0] pick_key(input int t);
    if (key_pool[t].size() == 0 || $urandom_range(9) == 0) return {$urandom, $urandom};
    return key_pool[t][$urandom_range(key_pool[t].size() - 1)];
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(9))
      0, 1:    return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(5, 1));
    endcase
  endfunction

  task automatic random_burst(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 8)
        push(OP_REG_PRODUCT, {$urandom, $urandom}, $urandom_range(15) != 0,
             64'($urandom), 1'($urandom), pick_limit(), 1'($urandom));
      else if (sel < 16)
        push(OP_REG_LISTENER, 64'($urandom), 1'($urandom), {$urandom, $urandom},
             $urandom_range(15) != 0, pick_limit(), 1'($urandom));
      else
        push(sel < 60 ? OP_ACQUIRE : OP_RELEASE, pick_key(0), $urandom_range(9) != 0,
             pick_key(1), $urandom_range(9) != 0, 16'($urandom), 1'($urandom));
    end
  endtask

  localparam logic [63:0] PK_A = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LK_A = 64'h0000_0000_0000_0000;
  localparam logic [63:0] PK_B = 64'hA5A5_0F0F_3C3C_9669;

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    steady             = 1'b0;
    in_operation       = OP_REG_PRODUCT;
    in_product_key     = '0;
    in_product_given   = 1'b0;
    in_listener_key    = '0;
    in_listener_given  = 1'b0;
    in_entry_limit     = '0;
    in_outcome_success = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_PRODUCT_CAP;
    cfg_data           = '0;
    tbl_used     = '{0, 0};
    tbl_cap      = '{DEPTH, DEPTH};
    warn_default = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Small tables first, so that the full case comes quickly.
    write_reg(CFG_PRODUCT_CAP, 16'd2);
    write_reg(CFG_LISTENER_CAP, 16'd1);
    write_reg(CFG_WARN_LEVEL, 16'd0);
    push(OP_ACQUIRE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b1);       // both tables empty
    push(OP_RELEASE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b0);
    push(OP_REG_PRODUCT, PK_A, 1'b0, LK_A, 1'b0, 16'd2, 1'b0);   // key missing
    push(OP_REG_PRODUCT, PK_A, 1'b1, LK_A, 1'b0, 16'd2, 1'b0);
    push(OP_REG_PRODUCT, PK_B, 1'b1, LK_A, 1'b0, 16'hFFFF, 1'b0);
    push(OP_REG_PRODUCT, PK_A, 1'b1, LK_A, 1'b0, 16'd1, 1'b0);   // full
    push(OP_REG_LISTENER, PK_A, 1'b0, LK_A, 1'b0, 16'd1, 1'b0);
    push(OP_REG_LISTENER, PK_A, 1'b0, LK_A, 1'b1, 16'd1, 1'b0);
    push(OP_REG_LISTENER, PK_A, 1'b0, PK_B, 1'b1, 16'd0, 1'b1);  // full
    push(OP_ACQUIRE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b0);       // ok with warnings
    push(OP_ACQUIRE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b0);       // listener over, rollback
    push(OP_ACQUIRE, PK_A, 1'b1, LK_A, 1'b0, 16'd0, 1'b0);
    push(OP_ACQUIRE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b0);       // product over
    push(OP_RELEASE, PK_A, 1'b1, LK_A, 1'b1, 16'hFFFF, 1'b1);
    push(OP_RELEASE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b0);
    push(OP_RELEASE, PK_A, 1'b1, LK_A, 1'b1, 16'd0, 1'b1);       // both at zero
    push(OP_ACQUIRE, PK_B, 1'b1, PK_B, 1'b1, 16'd0, 1'b1);       // listener unmatched
    push(OP_ACQUIRE, PK_A, 1'b0, LK_A, 1'b1, 16'd0, 1'b1);
    push(OP_ACQUIRE, ~PK_B, 1'b1, LK_A, 1'b1, 16'd0, 1'b1);      // product unmatched
    push(OP_RELEASE, PK_B, 1'b0, LK_A, 1'b0, 16'd0, 1'b1);
    drain();

    write_reg(CFG_PRODUCT_CAP, 16'd64);
    write_reg(CFG_LISTENER_CAP, 16'd64);
    write_reg(CFG_WARN_LEVEL, 16'hFFFF);
    steady = 1'b1;
    random_burst(150);
    drain();
    steady = 1'b0;
    random_burst(150);
    drain();

    write_reg(CFG_WARN_LEVEL, 16'd3);
    write_reg(CFG_PRODUCT_CAP, 16'd1);
    random_burst(200);
    drain();

    write_reg(CFG_PRODUCT_CAP, 16'(7'($urandom_range(64, 1))));
    write_reg(CFG_LISTENER_CAP, 16'(7'($urandom_range(64, 1))));
    write_reg(CFG_WARN_LEVEL, 16'($urandom));
    random_burst(250);
    drain();

    write_reg(CFG_PRODUCT_CAP, 16'd127);
    write_reg(CFG_LISTENER_CAP, 16'd64);
    write_reg(CFG_WARN_LEVEL, 16'd1);
    random_burst(250);
    drain();
    repeat (100) @(negedge clk);

    $display("checked %0d results: ok %0d, full %0d, product over %0d, listener over %0d,",
             checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("key missing %0d; tables hold %0d products and %0d listeners",
             status_seen[4], tbl_used[0], tbl_used[1]);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
